/* sv/sme_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, request codes and controller/datapath command and status
// types for the stable matching engine. No dependencies.
package sme_pkg;

    localparam int MAX_PAIRS = 8;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_PAIRS * MAX_PAIRS;

    localparam logic [CNT_W-1:0] PAIR_COUNT_RESET = 4'd8;
    localparam logic             REG_PAIR_COUNT   = 1'b0;

    typedef enum logic [1:0] {
        REQ_LOAD_MAN   = 2'd0,
        REQ_LOAD_WOMAN = 2'd1,
        REQ_START      = 2'd2
    } t_req;

    typedef struct packed {
        logic load_man;
        logic load_woman;
        logic start;
        logic find;
        logic wstart;
        logic wnext;
        logic accept_free;
        logic accept_switch;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic any_free;
        logic w_out_of_range;
        logic woman_free;
        logic same_man;
        logic e_is_cur;
        logic e_is_prop;
        logic scan_last;
        logic out_slot;
        logic out_last;
    } t_status;

endpackage

/* sv/sme_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result pairs.
// Depends on sme_pkg for field widths.
interface sme_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [sme_pkg::IDX_W-1:0] person;
    logic [sme_pkg::IDX_W-1:0] rank;
    logic [sme_pkg::IDX_W-1:0] choice;

    modport source (output valid, output req_type, output person, output rank,
                    output choice, input ready);
    modport sink   (input valid, input req_type, input person, input rank,
                    input choice, output ready);
endinterface

interface sme_out_if;
    logic                      valid;
    logic                      ready;
    logic [sme_pkg::IDX_W-1:0] woman;
    logic [sme_pkg::IDX_W-1:0] man;
    logic                      last;

    modport source (output valid, output woman, output man, output last, input ready);
    modport sink   (input valid, input woman, input man, input last, output ready);
endinterface

/* sv/sme_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the stable matching engine.
// Depends on sme_pkg for command and status types.
module sme_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_req_type,
    input  sme_pkg::t_status i_status,
    output logic             o_in_ready,
    output sme_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIND  = 5'b00010,
        S_MDATA = 5'b00100,
        S_WCMP  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (sme_pkg::t_req'(i_req_type))
                        sme_pkg::REQ_LOAD_MAN:   o_cmd.load_man = 1'b1;
                        sme_pkg::REQ_LOAD_WOMAN: o_cmd.load_woman = 1'b1;
                        sme_pkg::REQ_START: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_FIND;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIND: begin
                if (i_status.any_free) begin
                    o_cmd.find = 1'b1;
                    n_state    = S_MDATA;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MDATA: begin
                if (i_status.w_out_of_range) begin
                    n_state = S_FIND;
                end else if (i_status.woman_free) begin
                    o_cmd.accept_free = 1'b1;
                    n_state           = S_FIND;
                end else if (i_status.same_man) begin
                    n_state = S_FIND;
                end else begin
                    o_cmd.wstart = 1'b1;
                    n_state      = S_WCMP;
                end
            end
            S_WCMP: begin
                if (i_status.e_is_cur) begin
                    n_state = S_FIND;
                end else if (i_status.e_is_prop) begin
                    o_cmd.accept_switch = 1'b1;
                    n_state             = S_FIND;
                end else if (i_status.scan_last) begin
                    n_state = S_FIND;
                end else begin
                    o_cmd.wnext = 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_slot) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/sme_datapath.sv */
`timescale 1ns / 1ps
// Datapath: preference list memories, partner table, proposal pointers and
// the result output register. Depends on sme_pkg.
module sme_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sme_pkg::t_cmd             i_cmd,
    output sme_pkg::t_status          o_status,
    input  logic [sme_pkg::CNT_W-1:0] i_pair_count,
    input  logic [sme_pkg::IDX_W-1:0] i_person,
    input  logic [sme_pkg::IDX_W-1:0] i_rank,
    input  logic [sme_pkg::IDX_W-1:0] i_choice,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [sme_pkg::IDX_W-1:0] o_woman,
    output logic [sme_pkg::IDX_W-1:0] o_man,
    output logic                      o_last
);

    localparam int IDX_W = sme_pkg::IDX_W;
    localparam int CNT_W = sme_pkg::CNT_W;
    localparam int NP    = sme_pkg::MAX_PAIRS;

    logic [IDX_W-1:0] r_man_mem   [sme_pkg::DEPTH];
    logic [IDX_W-1:0] r_woman_mem [sme_pkg::DEPTH];
    logic [IDX_W-1:0] r_mrd;
    logic [IDX_W-1:0] r_wrd;

    logic [IDX_W-1:0] r_partner  [NP];
    logic [NP-1:0]    r_pvalid;
    logic [NP-1:0]    r_taken;
    logic [CNT_W-1:0] r_next_pos [NP];
    logic [IDX_W-1:0] r_cur_man;
    logic [IDX_W-1:0] r_cur_woman;
    logic [IDX_W-1:0] r_scan_idx;
    logic [IDX_W-1:0] r_out_idx;
    logic [CNT_W-1:0] r_n;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_woman;
    logic [IDX_W-1:0] r_out_man;
    logic             r_out_last;

    logic [CNT_W-1:0]          w_eff;
    logic                      w_found;
    logic [IDX_W-1:0]          w_sel;
    logic [sme_pkg::ADDR_W-1:0] w_man_addr;
    logic [sme_pkg::ADDR_W-1:0] w_woman_addr;
    logic [sme_pkg::ADDR_W-1:0] w_load_addr;

    // Count of zero runs as one; counts beyond the table size saturate.
    always_comb begin
        if (i_pair_count == '0) begin
            w_eff = CNT_W'(1);
        end else if (i_pair_count > CNT_W'(NP)) begin
            w_eff = CNT_W'(NP);
        end else begin
            w_eff = i_pair_count;
        end
    end

    // Lowest-numbered free man who still has an untried entry.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int m = NP - 1; m >= 0; m--) begin
            if (CNT_W'(m) < r_n && !r_taken[m] && r_next_pos[m] < r_n) begin
                w_found = 1'b1;
                w_sel   = IDX_W'(m);
            end
        end
    end

    assign w_man_addr   = {w_sel, r_next_pos[w_sel][IDX_W-1:0]};
    assign w_woman_addr = i_cmd.wstart ? {r_mrd, IDX_W'(0)}
                                       : {r_cur_woman, r_scan_idx + IDX_W'(1)};
    assign w_load_addr  = {i_person, i_rank};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_man) begin
            r_man_mem[w_load_addr] <= i_choice;
        end
        if (i_cmd.find) begin
            r_mrd <= r_man_mem[w_man_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_woman) begin
            r_woman_mem[w_load_addr] <= i_choice;
        end
        if (i_cmd.wstart || i_cmd.wnext) begin
            r_wrd <= r_woman_mem[w_woman_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid    <= '0;
            r_taken     <= '0;
            r_n         <= CNT_W'(NP);
            r_scan_idx  <= '0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int m = 0; m < NP; m++) begin
                r_next_pos[m] <= '0;
            end
        end else begin
            if (i_cmd.start) begin
                r_pvalid  <= '0;
                r_taken   <= '0;
                r_n       <= w_eff;
                r_out_idx <= '0;
                for (int m = 0; m < NP; m++) begin
                    r_next_pos[m] <= '0;
                end
            end
            if (i_cmd.find) begin
                r_next_pos[w_sel] <= r_next_pos[w_sel] + CNT_W'(1);
            end
            if (i_cmd.wstart) begin
                r_scan_idx <= '0;
            end
            if (i_cmd.wnext) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            if (i_cmd.accept_free) begin
                r_pvalid[r_mrd]    <= 1'b1;
                r_taken[r_cur_man] <= 1'b1;
            end
            if (i_cmd.accept_switch) begin
                r_taken[r_partner[r_cur_woman]] <= 1'b0;
                r_taken[r_cur_man]              <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= r_out_idx + IDX_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_cur_man <= w_sel;
        end
        if (i_cmd.wstart) begin
            r_cur_woman <= r_mrd;
        end
        if (i_cmd.accept_free) begin
            r_partner[r_mrd] <= r_cur_man;
        end
        if (i_cmd.accept_switch) begin
            r_partner[r_cur_woman] <= r_cur_man;
        end
        if (i_cmd.emit) begin
            r_out_woman <= r_out_idx;
            r_out_man   <= r_pvalid[r_out_idx] ? r_partner[r_out_idx] : '0;
            r_out_last  <= o_status.out_last;
        end
    end

    always_comb begin
        o_status.any_free       = w_found;
        o_status.w_out_of_range = CNT_W'(r_mrd) >= r_n;
        o_status.woman_free     = !r_pvalid[r_mrd];
        o_status.same_man       = r_partner[r_mrd] == r_cur_man;
        o_status.e_is_cur       = r_wrd == r_partner[r_cur_woman];
        o_status.e_is_prop      = r_wrd == r_cur_man;
        o_status.scan_last      = (CNT_W'(r_scan_idx) + CNT_W'(1)) >= r_n;
        o_status.out_slot       = !r_out_valid || i_out_ready;
        o_status.out_last       = (CNT_W'(r_out_idx) + CNT_W'(1)) == r_n;
    end

    assign o_out_valid = r_out_valid;
    assign o_woman     = r_out_woman;
    assign o_man       = r_out_man;
    assign o_last      = r_out_last;

endmodule

/* sv/stable_matching_engine.sv */
`timescale 1ns / 1ps
// Top level of the men-proposing stable matching engine: APB register,
// controller and datapath. Depends on sme_pkg, sme_if, sme_ctrl, sme_datapath.
//
//   Channel   Direction  Carries
//   -------   ---------  ---------------------------------------------------
//   i_in      sink       req_type, person, rank, choice (load or start)
//   o_out     source     woman, man, last (one pair per woman after a start)
//   APB       slave      pair_count at byte address 0
//
// Loads may follow one another every cycle while no start is in progress.
// A start first clears the matching state; each proposal then picks a man and
// inspects the woman, scanning her list entry by entry when she is already
// matched, and a last pick that finds no free man left ends the search; at most
// n*n proposals. The n result transfers then leave one per cycle while
// o_out.ready is high.
// Reset is synchronous and active low; it clears the matching state and sets
// pair_count to 8. The preference lists hold no defined value until loaded.
// i_in.ready is low from a start until its last pair is in the output
// register; a stalled output holds its pair and halts the result sequence.
module stable_matching_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    sme_in_if.sink       i_in,
    sme_out_if.source    o_out
);

    logic [sme_pkg::CNT_W-1:0] r_pair_count;
    logic                      w_reg_sel;
    sme_pkg::t_cmd             w_cmd;
    sme_pkg::t_status          w_status;

    // The register index is the word address; bit 2 selects it.
    assign w_reg_sel = (paddr[2] == sme_pkg::REG_PAIR_COUNT);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= sme_pkg::PAIR_COUNT_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_pair_count <= pwdata[sme_pkg::CNT_W-1:0];
        end
    end

    // Writes to addresses past the register list are dropped and read as zero.
    assign prdata = w_reg_sel ? {{(32 - sme_pkg::CNT_W){1'b0}}, r_pair_count} : 32'd0;

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_status   (w_status),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    sme_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_pair_count (r_pair_count),
        .i_person     (i_in.person),
        .i_rank       (i_in.rank),
        .i_choice     (i_in.choice),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_woman      (o_out.woman),
        .o_man        (o_out.man),
        .o_last       (o_out.last)
    );

endmodule
